[sv/svfs_pkg.sv]
// Shared types and constants for the floor-shadow projector.
// Used by the top level, svfs_front and svfs_back; depends on nothing.
package svfs_pkg;

	localparam int WORDS_PER_BONE = 12;
	localparam int MID_DEPTH      = 4;
	localparam int OUT_DEPTH      = 2;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	localparam logic [1:0] FAULT_OK  = 2'd0;
	localparam logic [1:0] FAULT_SEL = 2'd1;
	localparam logic [1:0] FAULT_OVF = 2'd2;

	localparam logic [2:0] CFG_LIGHT_X = 3'd0;
	localparam logic [2:0] CFG_LIGHT_Y = 3'd1;
	localparam logic [2:0] CFG_LIGHT_Z = 3'd2;
	localparam logic [2:0] CFG_FLOOR   = 3'd3;
	localparam logic [2:0] CFG_NODES   = 3'd4;

	// live configuration, plus the precomputed "light points down" check
	typedef struct packed {
		logic               light_ok;
		logic [6:0]         nodes;
		logic signed [31:0] lx;
		logic signed [31:0] ly;
		logic signed [31:0] lz;
		logic signed [31:0] fl;
	} cfg_t;

	// vertex with its fetched matrix, front to back
	typedef struct packed {
		logic                              fsel;
		logic                              hull;
		logic signed [31:0]                px;
		logic signed [31:0]                py;
		logic signed [31:0]                pz;
		logic [WORDS_PER_BONE-1:0][31:0]   w;
	} vert_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sz;
		logic [1:0]         fault;
		logic               hull;
	} res_t;

endpackage

[sv/skinned_vertex_floor_shadow.sv]
// Top level of the rigid-skinning floor-shadow projector.
// Depends on svfs_pkg, svfs_ram, svfs_fifo, svfs_front and svfs_back.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     push / full          kind bone_index matrix_word coefficient
//                                 pos_x pos_y pos_z hull_end
//  result    pop / empty          shadow_x shadow_z fault last_of_hull
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// One item per cycle while neither queue is full. A vertex passes 74
// registers: palette fetch (1), handoff queue (1), products, pose sums and
// projection (5), dividend sign and magnitude (1), a 64-stage restoring
// divider by light_y (64), final add and range check (1), result queue (1);
// the first loads on the accepting edge.
// Reset clears control only; the palette is undefined until written, so
// there is no clearing pass. The back pipe stalls as a whole while the
// result queue is full; the front keeps taking items until the handoff
// queue has no room. cfg_ready is always high.
module skinned_vertex_floor_shadow #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic [7:0]         bone_index,
	input  logic [3:0]         matrix_word,
	input  logic signed [31:0] coefficient,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic               hull_end,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] shadow_x,
	output logic signed [31:0] shadow_z,
	output logic [1:0]         fault,
	output logic               last_of_hull,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import svfs_pkg::*;

	localparam int MCW = $clog2(MID_DEPTH+1);
	localparam int OCW = $clog2(OUT_DEPTH+1);

	logic signed [31:0] lx_q, ly_q, lz_q, fl_q;
	logic [6:0]         nodes_q;
	logic signed [47:0] ly_scaled;
	cfg_t               cfg;

	logic           accept;
	logic           mid_push, mid_pop;
	vert_t          mid_wdata, mid_rdata;
	logic [MCW-1:0] mid_count;
	logic           out_push, out_pop;
	res_t           out_wdata, out_rdata;
	logic [OCW-1:0] out_count;

	// config registers; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q    <= '0;
			ly_q    <= 32'shFFFF0000;
			lz_q    <= '0;
			fl_q    <= '0;
			nodes_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LIGHT_X: lx_q    <= cfg_data;
				CFG_LIGHT_Y: ly_q    <= cfg_data;
				CFG_LIGHT_Z: lz_q    <= cfg_data;
				CFG_FLOOR:   fl_q    <= cfg_data;
				CFG_NODES:   nodes_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// light counts as downward when light_y * 10000 < -1.0
	assign ly_scaled    = 48'(ly_q) * 48'sd10000;
	assign cfg.light_ok = (ly_scaled + (48'sd1 <<< FRAC_BITS)) < 48'sd0;
	assign cfg.nodes    = nodes_q;
	assign cfg.lx       = lx_q;
	assign cfg.ly       = ly_q;
	assign cfg.lz       = lz_q;
	assign cfg.fl       = fl_q;

	// the fetch stage always lands in the handoff queue, so count it as taken
	assign full   = ({1'b0, mid_count} + {{MCW{1'b0}}, mid_push}) >= (MCW+1)'(MID_DEPTH);
	assign accept = push && !full;

	svfs_front #(.MAX_BONES(MAX_BONES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.kind        (kind),
		.bone_index  (bone_index),
		.matrix_word (matrix_word),
		.coefficient (coefficient),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.hull_end    (hull_end),
		.mid_push    (mid_push),
		.mid_vert    (mid_wdata)
	);

	svfs_fifo #(.W($bits(vert_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.count  (mid_count)
	);

	svfs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_avail (mid_count != '0),
		.in_vert  (mid_rdata),
		.in_pop   (mid_pop),
		.out_full (out_count == OCW'(OUT_DEPTH)),
		.out_push (out_push),
		.out_res  (out_wdata)
	);

	// result queue: its head is the port
	svfs_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (out_pop),
		.rdata  (out_rdata),
		.count  (out_count)
	);

	assign empty        = out_count == '0;
	assign out_pop      = pop && !empty;
	assign shadow_x     = out_rdata.sx;
	assign shadow_z     = out_rdata.sz;
	assign fault        = out_rdata.fault;
	assign last_of_hull = out_rdata.hull;

	// handoff queue must have room whenever the fetch stage delivers
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> (mid_count < MCW'(MID_DEPTH) || mid_pop))
		else $error("handoff queue overrun");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_count < OCW'(OUT_DEPTH))
		else $error("result queue overrun");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (fault == FAULT_OK || fault == FAULT_SEL || fault == FAULT_OVF))
		else $error("undefined fault code");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && fault != FAULT_OK) |-> (shadow_x == '0 && shadow_z == '0))
		else $error("faulted result carries coordinates");
endmodule

[sv/svfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svfs_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                         rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/svfs_fifo.sv]
// Small register FIFO; the caller must never push when full nor pop when
// empty, which the FIFO does not check. No dependencies.
module svfs_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= bump(wp_q);
			if (pop) rp_q <= bump(rp_q);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	assign rdata = mem_q[rp_q];
	assign count = cnt_q;
endmodule

[sv/svfs_front.sv]
// Front end: palette writes, matrix fetch, selector and light checks.
// Depends on svfs_pkg and svfs_ram (twelve banks, one per matrix word).
module svfs_front #(
	parameter int MAX_BONES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  svfs_pkg::cfg_t      cfg,
	input  logic                accept,
	input  logic                kind,
	input  logic [7:0]          bone_index,
	input  logic [3:0]          matrix_word,
	input  logic signed [31:0]  coefficient,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic                hull_end,
	output logic                mid_push,
	output svfs_pkg::vert_t     mid_vert
);
	import svfs_pkg::*;

	localparam int AW = MAX_BONES > 1 ? $clog2(MAX_BONES) : 1;

	logic          bone_ok;
	logic [8:0]    limit;
	logic [AW-1:0] addr;
	logic          vld_s1, fsel_s1, hull_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [WORDS_PER_BONE-1:0][31:0] word_rd;

	assign bone_ok = {1'b0, bone_index} < 9'(MAX_BONES);
	assign limit   = ({2'b00, cfg.nodes} < 9'(MAX_BONES)) ? {2'b00, cfg.nodes} : 9'(MAX_BONES);
	assign addr    = AW'(bone_index);

	for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_bank
		svfs_ram #(.W(32), .DEPTH(MAX_BONES)) u_bank (
			.clk   (clk),
			.we    (accept && kind == KIND_LOAD && bone_ok && matrix_word == 4'(k)),
			.waddr (addr),
			.wdata (coefficient),
			.raddr (addr),
			.rdata (word_rd[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			// loads and vertices under a non-downward light leave here
			vld_s1 <= accept && kind == KIND_VERTEX && cfg.light_ok;
		end
	end

	always_ff @(posedge clk) begin
		fsel_s1 <= {1'b0, bone_index} >= limit;
		hull_s1 <= hull_end;
		px_s1   <= pos_x;
		py_s1   <= pos_y;
		pz_s1   <= pos_z;
	end

	assign mid_push      = vld_s1;
	assign mid_vert.fsel = fsel_s1;
	assign mid_vert.hull = hull_s1;
	assign mid_vert.px   = px_s1;
	assign mid_vert.py   = py_s1;
	assign mid_vert.pz   = pz_s1;
	assign mid_vert.w    = word_rd;
endmodule

[sv/svfs_back.sv]
// Back end: pose transform, floor projection, pipelined divide by light_y.
// Depends on svfs_pkg. Whole pipe advances together unless the result queue is full.
module svfs_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  svfs_pkg::cfg_t   cfg,
	input  logic             in_avail,
	input  svfs_pkg::vert_t  in_vert,
	output logic             in_pop,
	input  logic             out_full,
	output logic             out_push,
	output svfs_pkg::res_t   out_res
);
	import svfs_pkg::*;

	localparam int SUMW = 67;
	localparam int DIVN = 64;
	localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (FRAC_BITS-1);

	logic adv;

	// s1: nine products
	logic               vld_s1, fsel_s1, hull_s1;
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] tr_s1 [3];
	// s2: partial sums
	logic                  vld_s2, fsel_s2, hull_s2;
	logic signed [SUMW-1:0] pa_s2 [3];
	logic signed [SUMW-1:0] pb_s2 [3];
	// s3: posed point
	logic               vld_s3, fsel_s3, hull_s3, ovf_s3;
	logic signed [31:0] q_s3 [3];
	// s4: height above floor
	logic               vld_s4, fsel_s4, hull_s4, ovf_s4;
	logic signed [31:0] qx_s4, qz_s4;
	logic signed [32:0] d_s4;
	// s5: dividends
	logic               vld_s5, fsel_s5, hull_s5, ovf_s5;
	logic signed [31:0] qx_s5, qz_s5;
	logic signed [64:0] nx_s5, nz_s5;
	// s6 .. s6+DIVN: restoring divider, one quotient bit per stage
	logic               vld_s6 [DIVN+1];
	logic               fsel_s6 [DIVN+1], hull_s6 [DIVN+1], ovf_s6 [DIVN+1];
	logic               negx_s6 [DIVN+1], negz_s6 [DIVN+1];
	logic signed [31:0] qx_s6 [DIVN+1], qz_s6 [DIVN+1];
	logic [31:0]        remx_s6 [DIVN+1], remz_s6 [DIVN+1];
	logic [63:0]        dqx_s6 [DIVN+1], dqz_s6 [DIVN+1];
	// s7: add and range check
	logic vld_s7;
	res_t res_s7;

	logic signed [SUMW-1:0] sum_c [3];
	logic signed [SUMW-1:0] sh_c [3];
	logic [2:0]             fit_c;
	logic [31:0]            dmag;
	logic signed [64:0]     qsx, qsz;
	logic signed [65:0]     sx_c, sz_c;
	logic                   fit2_c;

	assign adv      = !(vld_s7 && out_full);
	assign in_pop   = in_avail && adv;
	assign out_push = vld_s7 && !out_full;
	assign out_res  = res_s7;

	assign dmag = cfg.ly[31] ? (~cfg.ly + 32'd1) : cfg.ly;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = pa_s2[c] + pb_s2[c];
			sh_c[c]  = sum_c[c] >>> FRAC_BITS;
			fit_c[c] = (sh_c[c][SUMW-1:31] == '0) || (sh_c[c][SUMW-1:31] == '1);
		end
	end

	assign qsx  = negx_s6[DIVN] ? -$signed({1'b0, dqx_s6[DIVN]}) : $signed({1'b0, dqx_s6[DIVN]});
	assign qsz  = negz_s6[DIVN] ? -$signed({1'b0, dqz_s6[DIVN]}) : $signed({1'b0, dqz_s6[DIVN]});
	assign sx_c = 66'(qx_s6[DIVN]) + 66'(qsx);
	assign sz_c = 66'(qz_s6[DIVN]) + 66'(qsz);
	assign fit2_c = ((sx_c[65:31] == '0) || (sx_c[65:31] == '1)) &&
	                ((sz_c[65:31] == '0) || (sz_c[65:31] == '1));

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6[0] <= 1'b0;
			vld_s7    <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_pop;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6[0] <= vld_s5;
			vld_s7    <= vld_s6[DIVN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fsel_s1 <= in_vert.fsel;
			hull_s1 <= in_vert.hull;
			for (int c = 0; c < 3; c++) begin
				prod_s1[c][0] <= in_vert.px * $signed(in_vert.w[c]);
				prod_s1[c][1] <= in_vert.py * $signed(in_vert.w[3+c]);
				prod_s1[c][2] <= in_vert.pz * $signed(in_vert.w[6+c]);
				tr_s1[c]      <= $signed(in_vert.w[9+c]);
			end

			fsel_s2 <= fsel_s1;
			hull_s2 <= hull_s1;
			for (int c = 0; c < 3; c++) begin
				pa_s2[c] <= SUMW'(prod_s1[c][0]) + SUMW'(prod_s1[c][1]);
				pb_s2[c] <= (SUMW'(tr_s1[c]) <<< FRAC_BITS) + SUMW'(prod_s1[c][2]) + HALF;
			end

			fsel_s3 <= fsel_s2;
			hull_s3 <= hull_s2;
			ovf_s3  <= !(&fit_c);
			for (int c = 0; c < 3; c++) begin
				q_s3[c] <= sh_c[c][31:0];
			end

			fsel_s4 <= fsel_s3;
			hull_s4 <= hull_s3;
			ovf_s4  <= ovf_s3;
			qx_s4   <= q_s3[0];
			qz_s4   <= q_s3[2];
			d_s4    <= 33'(cfg.fl) - 33'(q_s3[1]);

			fsel_s5 <= fsel_s4;
			hull_s5 <= hull_s4;
			ovf_s5  <= ovf_s4;
			qx_s5   <= qx_s4;
			qz_s5   <= qz_s4;
			nx_s5   <= 65'(cfg.lx) * 65'(d_s4);
			nz_s5   <= 65'(cfg.lz) * 65'(d_s4);

			fsel_s6[0] <= fsel_s5;
			hull_s6[0] <= hull_s5;
			ovf_s6[0]  <= ovf_s5;
			qx_s6[0]   <= qx_s5;
			qz_s6[0]   <= qz_s5;
			negx_s6[0] <= nx_s5[64] ^ cfg.ly[31];
			negz_s6[0] <= nz_s5[64] ^ cfg.ly[31];
			remx_s6[0] <= '0;
			remz_s6[0] <= '0;
			dqx_s6[0]  <= nx_s5[64] ? 64'(-nx_s5) : nx_s5[63:0];
			dqz_s6[0]  <= nz_s5[64] ? 64'(-nz_s5) : nz_s5[63:0];

			res_s7.hull <= hull_s6[DIVN];
			if (fsel_s6[DIVN]) begin
				res_s7.fault <= FAULT_SEL;
				res_s7.sx    <= '0;
				res_s7.sz    <= '0;
			end else if (ovf_s6[DIVN] || !fit2_c) begin
				res_s7.fault <= FAULT_OVF;
				res_s7.sx    <= '0;
				res_s7.sz    <= '0;
			end else begin
				res_s7.fault <= FAULT_OK;
				res_s7.sx    <= sx_c[31:0];
				res_s7.sz    <= sz_c[31:0];
			end
		end
	end

	for (genvar k = 0; k < DIVN; k++) begin : g_div
		logic [32:0] trx, trz;
		logic        gex, gez;

		assign trx = {remx_s6[k], dqx_s6[k][63]};
		assign trz = {remz_s6[k], dqz_s6[k][63]};
		assign gex = trx >= {1'b0, dmag};
		assign gez = trz >= {1'b0, dmag};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s6[k+1] <= vld_s6[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fsel_s6[k+1] <= fsel_s6[k];
				hull_s6[k+1] <= hull_s6[k];
				ovf_s6[k+1]  <= ovf_s6[k];
				qx_s6[k+1]   <= qx_s6[k];
				qz_s6[k+1]   <= qz_s6[k];
				negx_s6[k+1] <= negx_s6[k];
				negz_s6[k+1] <= negz_s6[k];
				remx_s6[k+1] <= gex ? 32'(trx - {1'b0, dmag}) : trx[31:0];
				remz_s6[k+1] <= gez ? 32'(trz - {1'b0, dmag}) : trz[31:0];
				dqx_s6[k+1]  <= {dqx_s6[k][62:0], gex};
				dqz_s6[k+1]  <= {dqz_s6[k][62:0], gez};
			end
		end
	end
endmodule

[sim/tb_skinned_vertex_floor_shadow.sv]
// Self-checking testbench for skinned_vertex_floor_shadow: a directed table, then random
// matrix loads and vertices over several light/floor/node settings, checked by a local predictor.
// Depends on svfs_pkg and the RTL of the projector only.
module tb_skinned_vertex_floor_shadow;
	timeunit 1ns;
	timeprecision 1ps;
	import svfs_pkg::*;

	localparam int BONES     = 64;
	localparam int SETTLE    = 80;
	localparam int STALL_MAX = 5000;  // cycles with no beat on any channel
	localparam int HOLD_LEN  = 400;   // long receiver hold-off, fills the block
	localparam int PER_PHASE = 104;
	localparam logic signed [95:0] S32_MIN = -96'sd2147483648;
	localparam logic signed [95:0] S32_MAX = 96'sd2147483647;

	typedef struct {
		logic               kind;
		logic [7:0]         bone;
		logic [3:0]         word;
		logic signed [31:0] coef;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               hull;
	} vin_t;

	typedef struct {
		vin_t v;
		bit   typed;   // expected result written in the row itself
		res_t r;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               kind = KIND_LOAD;
	logic [7:0]         bone_index = '0;
	logic [3:0]         matrix_word = '0;
	logic signed [31:0] coefficient = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic               hull_end = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [31:0] shadow_x;
	logic signed [31:0] shadow_z;
	logic [1:0]         fault;
	logic               last_of_hull;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	skinned_vertex_floor_shadow u_top (.*);

	// predictor copy of the block's state
	logic signed [31:0] palette [BONES*WORDS_PER_BONE];
	bit                 written [BONES][WORDS_PER_BONE];
	logic signed [31:0] lx = 0, ly = -65536, lz = 0, fl = 0;
	logic [6:0]         nodes = '0;

	res_t  shadow_q[$];   // projected vertices still owed by the block
	int    errors = 0;
	int    results_seen = 0;
	bit    calm = 1'b0;   // no idling on either side
	int    quiet = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit fits32(logic signed [95:0] x);
		return x >= S32_MIN && x <= S32_MAX;
	endfunction

	// Skin the vertex by its bone and drop it onto the floor along the light.
	function automatic bit project_vertex(vin_t v, output res_t r);
		logic signed [95:0] p [3];
		logic signed [95:0] m [WORDS_PER_BONE];
		logic signed [95:0] q [3];
		logic signed [95:0] d, ly96, sx, sz;
		int                 lim;
		r = '0;
		r.hull = v.hull;
		ly96 = ly;
		if (ly96 * 10000 + 65536 >= 0)
			return 1'b0;  // light not pointing down: nothing comes out
		lim = (nodes > BONES) ? BONES : nodes;
		if (v.bone >= lim) begin
			r.fault = FAULT_SEL;
			return 1'b1;
		end
		p[0] = v.px;
		p[1] = v.py;
		p[2] = v.pz;
		for (int i = 0; i < WORDS_PER_BONE; i++)
			m[i] = palette[v.bone*WORDS_PER_BONE + i];
		// exact sum, round half up back to 16 fraction bits
		for (int c = 0; c < 3; c++)
			q[c] = (p[0]*m[c] + p[1]*m[3+c] + p[2]*m[6+c] + (m[9+c] <<< 16) + 32768) >>> 16;
		if (!fits32(q[0]) || !fits32(q[1]) || !fits32(q[2])) begin
			r.fault = FAULT_OVF;
			return 1'b1;
		end
		d  = 96'(fl) - q[1];
		sx = q[0] + (96'(lx) * d) / ly96;   // division truncates toward zero
		sz = q[2] + (96'(lz) * d) / ly96;
		if (!fits32(sx) || !fits32(sz)) begin
			r.fault = FAULT_OVF;
			return 1'b1;
		end
		r.sx = sx[31:0];
		r.sz = sz[31:0];
		r.fault = FAULT_OK;
		return 1'b1;
	endfunction

	// Update palette copy or queue the expected shadow for an accepted beat.
	task automatic absorb(vin_t v, bit typed, res_t tr);
		res_t r;
		if (v.kind == KIND_LOAD) begin
			if (v.bone < BONES && v.word < WORDS_PER_BONE) begin
				palette[v.bone*WORDS_PER_BONE + v.word] = v.coef;
				written[v.bone][v.word] = 1'b1;
			end
		end else if (project_vertex(v, r)) begin
			shadow_q.insert(shadow_q.size(), typed ? tr : r);
		end
	endtask

	task automatic put(vin_t v, bit typed = 0, res_t tr = '0);
		if (!calm)
			while ($urandom_range(0, 99) < 37) begin
				push <= 1'b0;
				@(posedge clk);
			end
		push        <= 1'b1;
		kind        <= v.kind;
		bone_index  <= v.bone;
		matrix_word <= v.word;
		coefficient <= v.coef;
		pos_x       <= v.px;
		pos_y       <= v.py;
		pos_z       <= v.pz;
		hull_end    <= v.hull;
		do @(posedge clk); while (full);
		absorb(v, typed, tr);
	endtask

	// valid stays up between writes; set_light drops it after the last one
	task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LIGHT_X: lx = data;
			CFG_LIGHT_Y: ly = data;
			CFG_LIGHT_Z: lz = data;
			CFG_FLOOR:   fl = data;
			CFG_NODES:   nodes = data[6:0];
			default: ;
		endcase
	endtask

	// Sender pause: every owed shadow back, then let loads drain too.
	task automatic drain();
		push <= 1'b0;
		while (shadow_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic vin_t mk_load(int b, int w, logic [31:0] c);
		vin_t v;
		v = '{KIND_LOAD, b[7:0], w[3:0], c, 32'($urandom), 32'($urandom), 32'($urandom),
			1'($urandom)};
		return v;
	endfunction

	function automatic vin_t mk_vert(int b, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit h);
		vin_t v;
		v = '{KIND_VERTEX, b[7:0], 4'($urandom), 32'($urandom), x, y, z, h};
		return v;
	endfunction

	// mostly small values so shadows land in range; now and then anything
	function automatic logic [31:0] rnd_val(int span);
		if ($urandom_range(0, 99) < 85)
			return 32'($signed($urandom_range(0, 2*span)) - span);
		return $urandom;
	endfunction

	// Random part of one phase: whole-matrix bursts, stray loads, vertices.
	task automatic random_phase();
		int n, lim, b, pick;
		int ok_bones[$];
		n = 0;
		while (n < PER_PHASE) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// a well-formed matrix: all twelve words of one bone
				b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BONES-1)
					: $urandom_range(0, 15);
				for (int w = 0; w < WORDS_PER_BONE; w++)
					put(mk_load(b, w, rnd_val(1 << 17)));
				n += WORDS_PER_BONE;
			end else if (pick < 25) begin
				// single word, sometimes to a bone or word that does not exist
				if ($urandom_range(0, 9) == 0)
					put(mk_load($urandom_range(0, 255), $urandom_range(12, 15), $urandom));
				else
					put(mk_load($urandom_range(0, BONES-1), $urandom_range(0, 11),
						rnd_val(1 << 17)));
				n++;
			end else begin
				lim = (nodes > BONES) ? BONES : nodes;
				ok_bones.delete();
				for (int i = 0; i < lim; i++)
					if (written[i].and() == 1'b1)
						ok_bones.insert(ok_bones.size(), i);
				// never select a bone that is in range but not fully loaded
				if (ok_bones.size() != 0 && $urandom_range(0, 99) < 85)
					b = ok_bones[$urandom_range(0, ok_bones.size()-1)];
				else
					b = $urandom_range(lim, 255);
				put(mk_vert(b, rnd_val(1 << 23), rnd_val(1 << 23), rnd_val(1 << 23),
					1'($urandom)));
				n++;
			end
		end
	endtask

	task automatic set_light(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] f, logic [6:0] nn);
		cfg_write(CFG_LIGHT_X, x);
		cfg_write(CFG_LIGHT_Y, y);
		cfg_write(CFG_LIGHT_Z, z);
		cfg_write(CFG_FLOOR, f);
		cfg_write(CFG_NODES, {25'd0, nn});
		cfg_valid <= 1'b0;
	endtask

	// Result side: check every popped beat, idle at random, one long hold-off.
	initial begin
		int    hold;
		bit    held;
		res_t  e;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				results_seen++;
				if (shadow_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result sx=%h sz=%h fault=%0d hull=%0b",
						$time, shadow_x, shadow_z, fault, last_of_hull);
				end else begin
					e = shadow_q.pop_front();
					if (shadow_x !== e.sx) begin
						errors++;
						$display("%0t: shadow_x expected %h actual %h", $time, e.sx, shadow_x);
					end
					if (shadow_z !== e.sz) begin
						errors++;
						$display("%0t: shadow_z expected %h actual %h", $time, e.sz, shadow_z);
					end
					if (fault !== e.fault) begin
						errors++;
						$display("%0t: fault expected %0d actual %0d", $time, e.fault, fault);
					end
					if (last_of_hull !== e.hull) begin
						errors++;
						$display("%0t: last_of_hull expected %0b actual %0b", $time, e.hull,
							last_of_hull);
					end
				end
				if (results_seen == 150 && !held) begin
					held = 1'b1;
					hold = HOLD_LEN;
				end
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	// Watchdog: any beat on any channel restarts the count.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		row_t tbl[$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// light straight down, floor at 0, one bone in use
		set_light(32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 7'd1);

		// bone 0 = identity, so the shadow is just (x, z)
		for (int w = 0; w < WORDS_PER_BONE; w++)
			tbl.insert(tbl.size(),
				'{mk_load(0, w, (w % 4 == 0 && w < 9) ? 32'h1_0000 : 32'h0), 0, '0});
		// loads to a bone past the palette and to word 15 are dropped
		tbl.insert(tbl.size(), '{mk_load(200, 0, 32'h1234_5678), 0, '0});
		tbl.insert(tbl.size(), '{mk_load(0, 15, 32'hDEAD_BEEF), 0, '0});
		tbl.insert(tbl.size(), '{mk_vert(0, 32'h1_0000, 32'h2_0000, 32'hFFFD_0000, 1), 1,
			'{32'sh1_0000, -32'sh3_0000, FAULT_OK, 1'b1}});
		// selector at nodes_in_use, and the largest selector
		tbl.insert(tbl.size(), '{mk_vert(1, 32'h5, 32'h6, 32'h7, 0), 1,
			'{0, 0, FAULT_SEL, 1'b0}});
		tbl.insert(tbl.size(), '{mk_vert(255, 32'hFFFF_FFFF, 32'h0, 32'h0, 1), 1,
			'{0, 0, FAULT_SEL, 1'b1}});
		// position extremes pass straight through the identity
		tbl.insert(tbl.size(), '{mk_vert(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0),
			1, '{32'sh7FFF_FFFF, 32'sh8000_0000, FAULT_OK, 1'b0}});
		// translation at max, one more unit of x overflows the posed x
		tbl.insert(tbl.size(), '{mk_load(0, 9, 32'h7FFF_FFFF), 0, '0});
		tbl.insert(tbl.size(), '{mk_vert(0, 32'h1_0000, 32'h0, 32'h0, 1), 1,
			'{0, 0, FAULT_OVF, 1'b1}});
		tbl.insert(tbl.size(),
			'{mk_vert(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0, '0});
		tbl.insert(tbl.size(), '{mk_load(0, 9, 32'h0), 0, '0});
		foreach (tbl[i])
			put(tbl[i].v, tbl[i].typed, tbl[i].r);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_light(32'h4000, 32'hFFFF_0000, 32'hFFFF_8000, 32'h0, 7'd64);
				1: set_light(rnd_val(1 << 17), -$urandom_range(70000, 1 << 20),
					rnd_val(1 << 17), rnd_val(1 << 20), 7'd64);
				// extremes of every register
				2: set_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
					7'd127);
				// just steep enough
				3: set_light(rnd_val(1 << 17), 32'hFFFF_FFF9, rnd_val(1 << 17),
					32'h8000_0000, 7'd5);
				// just too shallow: vertices give nothing
				4: set_light(rnd_val(1 << 17), 32'hFFFF_FFFA, rnd_val(1 << 17), 32'h0, 7'd64);
				// light pointing up, no nodes
				5: set_light(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 7'd0);
				6: set_light(rnd_val(1 << 16), 32'hFFFD_0000, rnd_val(1 << 16),
					rnd_val(1 << 18), 7'd64);
				default: set_light(32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0,
					7'd32);
			endcase
			calm = (ph == 6);
			random_phase();
			drain();
		end
		calm = 1'b0;

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
